// File: hdl/swhs_pkg.sv
// Shared types and fixed field widths of the sliding window histogram sampler.
package swhs_pkg;

   localparam int NOTE_W = 4;
   localparam int RAND_W = 16;
   localparam int CNT_W  = 7;
   localparam int CAP_W  = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [0:0] {
      FUNC_PUSH   = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   typedef logic [NOTE_W-1:0] note_type;
   typedef logic [RAND_W-1:0] rand_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [CAP_W-1:0]  cap_type;

endpackage

// File: hdl/swhs_if.sv
// Request and response channel interfaces of the histogram sampler.
interface swhs_req_if;
   logic               valid;
   logic               ready;
   swhs_pkg::func_type func;
   swhs_pkg::note_type note_value;
   swhs_pkg::rand_type random_value;

   modport source (output valid, output func, output note_value, output random_value,
                   input ready);
   modport sink (input valid, input func, input note_value, input random_value,
                 output ready);
endinterface

interface swhs_rsp_if;
   logic                valid;
   logic                ready;
   swhs_pkg::note_type  sampled_note;
   logic                used_fallback;
   swhs_pkg::count_type fill_count;

   modport source (output valid, output sampled_note, output used_fallback,
                   output fill_count, input ready);
   modport sink (input valid, input sampled_note, input used_fallback, input fill_count,
                 output ready);
endinterface

// File: hdl/swhs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module swhs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  write_enable,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] write_address,
   input  logic [WIDTH-1:0]                      write_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] read_address,
   output logic [WIDTH-1:0]                      read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data_ff <= mem[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// File: hdl/sliding_window_histogram_sampler.sv
// Sliding window note histogram with a roulette-wheel sampler.
//
// Words arrive on req_if (valid/ready). A push (func FUNC_PUSH) stores note_value in
// the window ring and counts it in its bin, evicting the oldest note first when the
// window has reached csr_write_data's capacity. A sample (FUNC_SAMPLE) returns the
// first bin whose running total times 65535 reaches random_value times the fill.
// Every request word gives exactly one response word on rsp_if, in order.
// The block works on one word at a time. A push of a note of BINS or more stores
// nothing and goes straight to S_DONE. Any other push passes through S_INS and S_INC,
// after S_EV_RD, S_EV_BIN and S_EV_DEC when it evicts; the ring RAM and the bin RAM
// each give one read a cycle and the read, modify and write of the bins sets these
// states. A sample walks the bin RAM one bin a cycle, up to BINS bins, before its
// response; an empty window goes straight to S_DONE with the fallback note. The input
// is ready again the cycle after the response is loaded.
// The response sits in an output register, so a new request is accepted while the
// last response waits; a stalled receiver holds the next response back in the final
// state until the register frees up. Reset empties the window, clears every bin
// at once through per-bin valid flags and sets the capacity to 64.
module sliding_window_histogram_sampler #(
   parameter int DEPTH = 64,
   parameter int BINS  = 12
) (
   input  logic                clock,
   input  logic                reset,
   swhs_req_if.sink            req_if,
   swhs_rsp_if.source          rsp_if,
   input  logic                csr_write_enable,
   input  swhs_pkg::cap_type   csr_write_data
);

   import swhs_pkg::*;

   localparam int AW       = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int BW       = $clog2(BINS);
   localparam int SUM_W    = (AW > CNT_W ? AW : CNT_W) + 1;
   localparam int TGT_W    = RAND_W + CNT_W;
   localparam int SCL_W    = CNT_W + 1 + RAND_W;
   localparam int FALLBACK = DEPTH % BINS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EV_RD,
      S_EV_BIN,
      S_EV_DEC,
      S_INS,
      S_INC,
      S_WALK,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   cap_type            cap_ff, cap_in;
   count_type          count_ff, count_in;
   logic [AW-1:0]      oldest_ff, oldest_in;
   logic [BINS-1:0]    vld_ff, vld_in;
   logic [BW-1:0]      bidx_ff, bidx_in;
   logic [CNT_W:0]     cum_ff, cum_in;
   logic [TGT_W-1:0]   target_ff, target_in;
   logic [BW-1:0]      note_ff, note_in;
   logic [BW-1:0]      ev_ff, ev_in;
   note_type           res_note_ff, res_note_in;
   logic               res_fb_ff, res_fb_in;
   logic               rsp_valid_ff, rsp_valid_in;
   note_type           rsp_note_ff, rsp_note_in;
   logic               rsp_fb_ff, rsp_fb_in;
   count_type          rsp_fill_ff, rsp_fill_in;
   logic [BW-1:0]      bin_raddr_ff;

   logic               bin_we;
   logic [BW-1:0]      bin_waddr, bin_raddr;
   count_type          bin_wdata, bin_rdata, bin_q;
   logic               ring_we;
   logic [AW-1:0]      ring_waddr;
   note_type           ring_wdata, ring_rdata;

   count_type          eff_cap;
   logic [SUM_W-1:0]   slot_sum;
   logic [AW-1:0]      slot;
   logic [CNT_W:0]     cum_sum;
   logic [SCL_W-1:0]   scaled;
   logic [BW+NOTE_W-1:0] req_note_ext, ring_note_ext;
   logic               req_in_range;

   swhs_ram #(.WIDTH(NOTE_W), .DEPTH(DEPTH)) u_ring (
      .clock         (clock),
      .write_enable  (ring_we),
      .write_address (ring_waddr),
      .write_data    (ring_wdata),
      .read_address  (oldest_ff),
      .read_data     (ring_rdata)
   );

   swhs_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_bins (
      .clock         (clock),
      .write_enable  (bin_we),
      .write_address (bin_waddr),
      .write_data    (bin_wdata),
      .read_address  (bin_raddr),
      .read_data     (bin_rdata)
   );

   // A bin never written since reset reads as zero.
   assign bin_q = vld_ff[bin_raddr_ff] ? bin_rdata : '0;

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = count_type'(1);
      end else if (int'(cap_ff) > DEPTH) begin
         eff_cap = count_type'(DEPTH);
      end else begin
         eff_cap = count_type'(cap_ff);
      end
   end

   assign req_note_ext  = {{BW{1'b0}}, req_if.note_value};
   assign ring_note_ext = {{BW{1'b0}}, ring_rdata};
   assign req_in_range  = req_note_ext < (BW+NOTE_W)'(BINS);

   // The fill never exceeds the depth, so one subtraction wraps the slot index.
   assign slot_sum = SUM_W'(oldest_ff) + SUM_W'(count_ff);
   assign slot     = (slot_sum >= SUM_W'(DEPTH)) ? AW'(slot_sum - SUM_W'(DEPTH))
                                                 : AW'(slot_sum);

   assign cum_sum = cum_ff + {1'b0, bin_q};
   assign scaled  = {cum_sum, {RAND_W{1'b0}}} - SCL_W'(cum_sum);

   always_comb begin
      state_in     = state_ff;
      cap_in       = csr_write_enable ? csr_write_data : cap_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      vld_in       = vld_ff;
      bidx_in      = bidx_ff;
      cum_in       = cum_ff;
      target_in    = target_ff;
      note_in      = note_ff;
      ev_in        = ev_ff;
      res_note_in  = res_note_ff;
      res_fb_in    = res_fb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_note_in  = rsp_note_ff;
      rsp_fb_in    = rsp_fb_ff;
      rsp_fill_in  = rsp_fill_ff;
      bin_we       = 1'b0;
      bin_waddr    = ev_ff;
      bin_wdata    = bin_q;
      bin_raddr    = note_ff;
      ring_we      = 1'b0;
      ring_waddr   = slot;
      ring_wdata   = note_type'(note_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               res_note_in = '0;
               res_fb_in   = 1'b0;
               note_in     = req_note_ext[BW-1:0];
               if (req_if.func == FUNC_SAMPLE) begin
                  target_in = TGT_W'(req_if.random_value) * TGT_W'(count_ff);
                  cum_in    = '0;
                  bidx_in   = '0;
                  bin_raddr = '0;
                  if (count_ff == '0) begin
                     res_note_in = note_type'(FALLBACK);
                     res_fb_in   = 1'b1;
                     state_in    = S_DONE;
                  end else begin
                     state_in = S_WALK;
                  end
               end else if (!req_in_range) begin
                  state_in = S_DONE;
               end else if (count_ff >= eff_cap) begin
                  state_in = S_EV_RD;
               end else begin
                  state_in = S_INS;
               end
            end
         end
         S_EV_RD: begin
            state_in = S_EV_BIN;
         end
         S_EV_BIN: begin
            ev_in     = ring_note_ext[BW-1:0];
            bin_raddr = ring_note_ext[BW-1:0];
            state_in  = S_EV_DEC;
         end
         S_EV_DEC: begin
            if (bin_q != '0) begin
               bin_we           = 1'b1;
               bin_waddr        = ev_ff;
               bin_wdata        = bin_q - count_type'(1);
               vld_in[ev_ff]    = 1'b1;
            end
            oldest_in = (oldest_ff == AW'(DEPTH - 1)) ? '0 : oldest_ff + AW'(1);
            count_in  = count_ff - count_type'(1);
            state_in  = S_INS;
         end
         S_INS: begin
            ring_we    = 1'b1;
            ring_waddr = slot;
            bin_raddr  = note_ff;
            state_in   = S_INC;
         end
         S_INC: begin
            bin_we          = 1'b1;
            bin_waddr       = note_ff;
            bin_wdata       = bin_q + count_type'(1);
            vld_in[note_ff] = 1'b1;
            count_in        = count_ff + count_type'(1);
            state_in        = S_DONE;
         end
         S_WALK: begin
            cum_in    = cum_sum;
            bin_raddr = bidx_ff + BW'(1);
            if (scaled >= SCL_W'(target_ff)) begin
               res_note_in = note_type'(bidx_ff);
               state_in    = S_DONE;
            end else if (bidx_ff == BW'(BINS - 1)) begin
               res_note_in = note_type'(FALLBACK);
               res_fb_in   = 1'b1;
               state_in    = S_DONE;
            end else begin
               bidx_in = bidx_ff + BW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_note_in  = res_note_ff;
               rsp_fb_in    = res_fb_ff;
               rsp_fill_in  = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         oldest_ff    <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bidx_ff      <= bidx_in;
      cum_ff       <= cum_in;
      target_ff    <= target_in;
      note_ff      <= note_in;
      ev_ff        <= ev_in;
      res_note_ff  <= res_note_in;
      res_fb_ff    <= res_fb_in;
      rsp_note_ff  <= rsp_note_in;
      rsp_fb_ff    <= rsp_fb_in;
      rsp_fill_ff  <= rsp_fill_in;
      bin_raddr_ff <= bin_raddr;
   end

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.sampled_note  = rsp_note_ff;
   assign rsp_if.used_fallback = rsp_fb_ff;
   assign rsp_if.fill_count    = rsp_fill_ff;

endmodule

// File: sim/tb_sliding_window_histogram_sampler.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window histogram sampler.
module tb_sliding_window_histogram_sampler;
   import swhs_pkg::*;

   localparam int BIN_COUNT = 12;
   localparam int WINDOW_DEPTH = 64;
   localparam note_type FALLBACK_NOTE = note_type'(WINDOW_DEPTH % BIN_COUNT);
   localparam longint unsigned FULL_SCALE = 65535;
   localparam int HOLD_CYCLES = 250;
   localparam int QUIET_LIMIT = 3000;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      func_type func;
      note_type note;
      rand_type rnd;
   } request_word_type;

   typedef struct packed {
      note_type note;
      logic fallback;
      count_type fill;
   } response_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   cap_type csr_write_data;

   swhs_req_if req_if ();
   swhs_rsp_if rsp_if ();

   sliding_window_histogram_sampler uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Own copy of the window, the bins and the capacity register.
   note_type win_ring [WINDOW_DEPTH];
   logic [5:0] win_head = '0;
   count_type win_fill = '0;
   count_type bin_tally [BIN_COUNT] = '{default: '0};
   cap_type win_capacity = CAP_RESET;

   request_word_type pending_requests [$];
   response_word_type predicted_responses [$];
   request_word_type offered_word = '0;
   int unsigned queued_total = 0;
   int unsigned checked_total = 0;
   int unsigned error_count = 0;
   int unsigned send_wait = 0;
   int unsigned recv_wait = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned quiet_cycles = 0;
   logic send_gaps_on = 1'b1;
   logic recv_gaps_on = 1'b1;

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 40)
         $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Mostly no gap, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      else if (roll < 85) return $urandom_range(3, 1);
      else if (roll < 97) return $urandom_range(12, 4);
      else return $urandom_range(60, 20);
   endfunction

   task automatic apply_to_window(input request_word_type w);
      response_word_type resp;
      int unsigned limit;
      longint unsigned target;
      longint unsigned running;
      note_type gone;
      logic [5:0] slot;
      logic found;
      resp = '0;
      if (w.func == FUNC_PUSH) begin
         if (w.note < BIN_COUNT) begin
            limit = (win_capacity == 0) ? 1 :
                    (win_capacity > WINDOW_DEPTH) ? WINDOW_DEPTH : win_capacity;
            // A push into a full (or over-full) window drops exactly one oldest note.
            if (win_fill >= limit && win_fill != 0) begin
               gone = win_ring[win_head];
               if (bin_tally[gone] != 0) bin_tally[gone]--;
               win_head++;
               win_fill--;
            end
            slot = win_head + win_fill[5:0];
            win_ring[slot] = w.note;
            win_fill++;
            bin_tally[w.note]++;
         end
      end else if (win_fill == 0) begin
         resp.note = FALLBACK_NOTE;
         resp.fallback = 1'b1;
      end else begin
         target = 64'(w.rnd) * 64'(win_fill);
         running = 0;
         found = 1'b0;
         resp.note = FALLBACK_NOTE;
         resp.fallback = 1'b1;
         for (int b = 0; b < BIN_COUNT; b++) begin
            running += bin_tally[b];
            if (!found && running * FULL_SCALE >= target) begin
               found = 1'b1;
               resp.note = note_type'(b);
               resp.fallback = 1'b0;
            end
         end
      end
      resp.fill = win_fill;
      predicted_responses.push_back(resp);
   endtask

   always @(posedge clock) begin : req_driver
      logic offering;
      if (csr_write_enable) win_capacity = csr_write_data;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_wait = 0;
      end else begin
         offering = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            apply_to_window(offered_word);
            offering = 1'b0;
            send_wait = send_gaps_on ? pick_gap() : 0;
         end
         if (!offering) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_requests.size() > 0) begin
               offered_word = pending_requests.pop_front();
               offering = 1'b1;
            end
         end
         req_if.valid <= offering;
         req_if.func <= offered_word.func;
         req_if.note_value <= offered_word.note;
         req_if.random_value <= offered_word.rnd;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      response_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (predicted_responses.size() == 0) begin
               report_mismatch("result with nothing expected, fill_count", rsp_if.fill_count, 0);
            end else begin
               want = predicted_responses.pop_front();
               if (rsp_if.sampled_note !== want.note)
                  report_mismatch("sampled_note", rsp_if.sampled_note, want.note);
               if (rsp_if.used_fallback !== want.fallback)
                  report_mismatch("used_fallback", rsp_if.used_fallback, want.fallback);
               if (rsp_if.fill_count !== want.fill)
                  report_mismatch("fill_count", rsp_if.fill_count, want.fill);
               checked_total++;
            end
            recv_wait = recv_gaps_on ? pick_gap() : 0;
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            recv_wait = HOLD_CYCLES;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic queue_word(input func_type f, input note_type note, input rand_type rnd);
      request_word_type w;
      w.func = f;
      w.note = note;
      w.rnd = rnd;
      pending_requests.push_back(w);
      queued_total++;
   endtask

   task automatic queue_random_words(input int count, input int push_weight);
      int unsigned roll;
      rand_type rnd;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         rnd = rand_type'($urandom_range(16'hFFFF));
         if ($urandom_range(9) == 0)
            rnd = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         if (roll < 5)
            queue_word(FUNC_PUSH, note_type'($urandom_range(15, BIN_COUNT)), rnd);
         else if (roll < push_weight)
            queue_word(FUNC_PUSH, note_type'($urandom_range(BIN_COUNT - 1)), rnd);
         else
            queue_word(FUNC_SAMPLE, note_type'($urandom_range(15)), rnd);
      end
   endtask

   // The register is only written once every word sent so far has been answered.
   task automatic set_capacity(input cap_type value);
      while (checked_total != queued_total) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      cap_type phase_caps [12];
      phase_caps = '{7'd3, 7'd7, 7'd12, 7'd33, 7'd63, 7'd64, 7'd127, 7'd100,
                     7'd5, 7'd1, 7'd0, 7'd64};
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.func = FUNC_PUSH;
      req_if.note_value = '0;
      req_if.random_value = '0;
      rsp_if.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty window: samples fall back, out-of-range pushes leave it empty.
      queue_word(FUNC_SAMPLE, 4'd0, 16'h0000);
      queue_word(FUNC_SAMPLE, 4'd15, 16'hFFFF);
      queue_word(FUNC_PUSH, 4'd12, 16'h1234);
      queue_word(FUNC_PUSH, 4'd15, 16'hFFFF);
      queue_word(FUNC_SAMPLE, 4'd7, 16'h3039);

      // A capacity of zero behaves as one.
      set_capacity(7'd0);
      queue_word(FUNC_PUSH, 4'd3, 16'h0000);
      queue_word(FUNC_PUSH, 4'd11, 16'h0000);
      queue_word(FUNC_SAMPLE, 4'd0, 16'h0000);
      queue_word(FUNC_SAMPLE, 4'd0, 16'hFFFF);
      queue_word(FUNC_PUSH, 4'd0, 16'hFFFF);
      queue_word(FUNC_SAMPLE, 4'd0, 16'h8000);

      set_capacity(7'd1);
      queue_word(FUNC_PUSH, 4'd5, 16'h0000);
      queue_word(FUNC_SAMPLE, 4'd0, 16'h0001);

      set_capacity(7'd2);
      queue_word(FUNC_PUSH, 4'd0, 16'h0000);
      queue_word(FUNC_PUSH, 4'd11, 16'h0000);
      queue_word(FUNC_PUSH, 4'd7, 16'h0000);
      queue_word(FUNC_SAMPLE, 4'd0, 16'h0000);
      queue_word(FUNC_SAMPLE, 4'd0, 16'hFFFF);
      queue_word(FUNC_SAMPLE, 4'd0, 16'h7FFF);
      queue_word(FUNC_SAMPLE, 4'd0, 16'h8000);

      // Capacities rise first, then drop below a full window, which must stay full.
      for (int p = 0; p < 12; p++) begin
         set_capacity(phase_caps[p]);
         if (p == 6) begin
            // Receiver stalls for a long stretch while words keep coming.
            send_gaps_on = 1'b0;
            hold_requests++;
            queue_random_words(60, 60);
            while (checked_total != queued_total) @(posedge clock);
         end
         send_gaps_on = (p % 4) < 2;
         recv_gaps_on = (p % 2) == 0;
         queue_random_words(100, (phase_caps[p] > 30) ? 70 : 55);
      end

      while (checked_total != queued_total) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (predicted_responses.size() != 0)
         report_mismatch("results never arrived", predicted_responses.size(), 0);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
